[sv/twcr_pkg.sv]
// ----------------------------------------------------------------------------
// twcr_pkg
// shared types, command codes and lookup helpers for the two-wire responder
// ----------------------------------------------------------------------------
package twcr_pkg;

    localparam int RSP_BITS  = 16;
    localparam int BIT_CNT_W = $clog2(RSP_BITS);
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    // command bytes
    localparam logic [7:0] CMD_PING  = 8'd34;
    localparam logic [7:0] CMD_SON   = 8'd140;
    localparam logic [7:0] CMD_SOF   = 8'd218;
    localparam logic [7:0] CMD_SM    = 8'd107;
    localparam logic [7:0] CMD_GM    = 8'd122;
    localparam logic [7:0] CMD_GSC   = 8'd94;
    localparam logic [7:0] CMD_SSC   = 8'd209;
    localparam logic [7:0] CMD_GOSTM = 8'd157;
    localparam logic [7:0] CMD_KEN   = 8'd255;
    localparam logic [7:0] CMD_KDIS  = 8'd227;

    // response first bytes
    localparam logic [7:0] RSP_ACK   = 8'd47;
    localparam logic [7:0] RSP_NACK  = 8'd52;

    localparam logic [7:0] MODE_CUSTOM = 8'd69;

    localparam int N_SWITCH = 10;
    localparam int N_MODES  = 7;

    localparam logic [7:0] SWITCH_TARGETS [N_SWITCH] = '{
        8'd230, 8'd143, 8'd205, 8'd139, 8'd155, 8'd212, 8'd172, 8'd189, 8'd57, 8'd199
    };
    localparam logic [7:0] MODE_CODES [N_MODES] = '{
        8'd60, 8'd71, 8'd82, 8'd93, 8'd104, 8'd115, 8'd126
    };

    typedef struct packed {
        logic        vld;
        logic [15:0] word;
    } t_rsp_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic is_switch_target(input logic [7:0] par);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < N_SWITCH; i++) begin
            if (SWITCH_TARGETS[i] == par) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic is_mode_code(input logic [7:0] par);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < N_MODES; i++) begin
            if (MODE_CODES[i] == par) hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

[sv/twcr_front.sv]
// ----------------------------------------------------------------------------
// twcr_front
// line sampler, command window and decoder; pushes response words
// ----------------------------------------------------------------------------
module twcr_front
    import twcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_line_a,
    input  logic       i_line_b,
    input  logic [6:0] i_status_pins,
    output t_rsp_push  o_push
);

    logic        r_prev_pause, n_prev_pause;
    logic [15:0] r_window, n_window;
    logic [7:0]  r_mode, n_mode;
    logic [7:0]  r_sys_clk, n_sys_clk;

    logic [15:0] w_shift;
    logic [7:0]  w_cmd;
    logic [7:0]  w_par;

    assign w_shift = {r_window[14:0], i_line_b};
    assign w_cmd   = w_shift[15:8];
    assign w_par   = w_shift[7:0];

    always_comb begin
        n_prev_pause = r_prev_pause;
        n_window     = r_window;
        n_mode       = r_mode;
        n_sys_clk    = r_sys_clk;
        o_push       = '0;
        if (i_accept) begin
            if (!i_line_a) begin
                n_prev_pause = 1'b1;
            end else if (r_prev_pause) begin
                n_prev_pause = 1'b0;
                n_window     = w_shift;
                // second byte of ping/switch/set-mode is the cleared response word low byte
                unique case (w_cmd) inside
                    CMD_PING: begin
                        o_push = '{vld: 1'b1, word: {RSP_ACK, 8'd0}};
                    end
                    CMD_SON, CMD_SOF: begin
                        if (is_switch_target(w_par)) begin
                            n_mode = MODE_CUSTOM;
                            o_push = '{vld: 1'b1, word: {RSP_ACK, 8'd0}};
                        end else begin
                            o_push = '{vld: 1'b1, word: {RSP_NACK, 8'd0}};
                        end
                    end
                    CMD_SM: begin
                        if (is_mode_code(w_par)) begin
                            n_mode = w_par;
                            o_push = '{vld: 1'b1, word: {RSP_ACK, 8'd0}};
                        end else begin
                            o_push = '{vld: 1'b1, word: {RSP_NACK, 8'd0}};
                        end
                    end
                    CMD_GM: begin
                        o_push = '{vld: 1'b1, word: {RSP_ACK, r_mode}};
                    end
                    CMD_GSC: begin
                        o_push = '{vld: 1'b1, word: {RSP_ACK, r_sys_clk}};
                    end
                    CMD_SSC: begin
                        n_sys_clk = w_par;
                        o_push    = '{vld: 1'b1, word: {RSP_ACK, 8'd0}};
                    end
                    CMD_GOSTM: begin
                        o_push = '{vld: 1'b1, word: {RSP_ACK, i_status_pins, 1'b1}};
                    end
                    CMD_KEN: begin
                        o_push = '{vld: 1'b1, word: {RSP_ACK, CMD_KEN}};
                    end
                    CMD_KDIS: begin
                        o_push = '{vld: 1'b1, word: {RSP_ACK, CMD_KDIS}};
                    end
                    default: begin
                        o_push = '0;
                    end
                endcase
            end else begin
                // repeated data symbol without a pause
                n_prev_pause = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pause <= 1'b0;
            r_window     <= '0;
            r_mode       <= '0;
            r_sys_clk    <= '0;
        end else begin
            r_prev_pause <= n_prev_pause;
            r_window     <= n_window;
            r_mode       <= n_mode;
            r_sys_clk    <= n_sys_clk;
        end
    end

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.vld |-> (i_accept && i_line_a && r_prev_pause))
        else $error("response pushed without a counted bit");

endmodule

[sv/twcr_fifo.sv]
// ----------------------------------------------------------------------------
// twcr_fifo
// short response word queue between decoder and serializer
// ----------------------------------------------------------------------------
module twcr_fifo
    import twcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rsp_push   i_push,
    input  logic        i_pop,
    output logic [15:0] o_word,
    output t_q_stat     o_stat
);

    logic [15:0]     r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, n_wptr;
    logic [Q_AW-1:0] r_rptr, n_rptr;
    logic [Q_CW-1:0] r_cnt, n_cnt;

    assign o_word       = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push.vld) n_wptr = ptr_inc(r_wptr);
        if (i_pop)      n_rptr = ptr_inc(r_rptr);
        if (i_push.vld && !i_pop)      n_cnt = r_cnt + 1'b1;
        else if (!i_push.vld && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) r_mem[r_wptr] <= i_push.word;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

[sv/twcr_back.sv]
// ----------------------------------------------------------------------------
// twcr_back
// response serializer: sends each queued word msb first, 16 transactions
// ----------------------------------------------------------------------------
module twcr_back
    import twcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_word,
    input  t_q_stat     i_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_bit,
    output logic        o_last_bit
);

    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(RSP_BITS - 1);

    logic                 r_busy, n_busy;
    logic [BIT_CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]          r_word, n_word;
    logic                 w_take;

    assign o_valid    = r_busy;
    assign o_tx_bit   = r_word[15];
    assign o_last_bit = (r_cnt == BIT_LAST);
    assign w_take     = r_busy && !i_stall;
    assign o_pop      = (!r_busy || (w_take && o_last_bit)) && !i_stat.empty;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_word = r_word;
        if (w_take) begin
            n_word = {r_word[14:0], 1'b0};
            n_cnt  = r_cnt + 1'b1;
            if (o_last_bit) n_busy = 1'b0;
        end
        if (o_pop) begin
            n_word = i_word;
            n_cnt  = '0;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_last_bit && i_stat.empty) |=> !o_valid)
        else $error("serializer kept running with nothing queued");

endmodule

[sv/two_wire_command_responder_top.sv]
// ----------------------------------------------------------------------------
// two_wire_command_responder_top
// two-wire line command decoder with serial ack/nack responses
// ----------------------------------------------------------------------------
// input channel: one line sample per transaction (i_line_a, i_line_b,
// i_status_pins), taken when i_valid is high and o_stall is low. a low
// line_a is a pause; a high line_a right after a pause shifts line_b into
// the 16-bit command window, which is then decoded.
// output channel: a recognized command yields 16 transactions (o_tx_bit,
// msb first, o_last_bit on the sixteenth), moved when o_valid is high and
// i_stall is low.
// the decoder takes one sample per cycle while o_stall is low; a response
// word goes into a two-entry queue and the serializer drains it at one bit
// per cycle while i_stall is low, loading each word into its shift register;
// sustained throughput is set by the serializer: 16 bits per response.
// o_stall rises only while the queue holds two words.
// reset clears the window, mode, clock byte, queue and serializer.
// a stalled output holds its bit until taken; the input side keeps going
// until the queue fills.
// ----------------------------------------------------------------------------
module two_wire_command_responder_top
    import twcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_line_a,
    input  logic       i_line_b,
    input  logic [6:0] i_status_pins,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_tx_bit,
    output logic       o_last_bit
);

    t_rsp_push   w_push;
    t_q_stat     w_stat;
    logic [15:0] w_word;
    logic        w_pop;
    logic        w_accept;

    assign o_stall  = w_stat.full;
    assign w_accept = i_valid && !o_stall;

    twcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_line_a      (i_line_a),
        .i_line_b      (i_line_b),
        .i_status_pins (i_status_pins),
        .o_push        (w_push)
    );

    twcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_word  (w_word),
        .o_stat  (w_stat)
    );

    twcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (w_word),
        .i_stat     (w_stat),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_tx_bit   (o_tx_bit),
        .o_last_bit (o_last_bit)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-wire command responder: line samples are
// driven over the valid/stall input channel, a scoreboard decodes the same
// samples and predicts every serial response bit, and each bit taken from
// the output channel is compared in order
// ----------------------------------------------------------------------------
module tb_top
    import twcr_pkg::*;
();

    class twcr_scoreboard;

        typedef struct packed {
            logic tx_bit;
            logic last_bit;
        } t_rsp_bit;

        t_rsp_bit    rsp_bits_q[$];
        logic        prev_pause;
        logic [15:0] window;
        logic [7:0]  mode;
        logic [7:0]  clk_byte;
        logic [15:0] rsp_word;
        bit          rsp_written;
        int          errors;
        int          n_samples;
        int          n_responses;
        int          n_checked;

        function new();
            prev_pause  = 1'b0;
            window      = '0;
            mode        = '0;
            clk_byte    = '0;
            rsp_word    = '0;
            rsp_written = 1'b0;
            errors      = 0;
            n_samples   = 0;
            n_responses = 0;
            n_checked   = 0;
        endfunction

        function bit switch_param(logic [7:0] p);
            case (p)
                8'd230, 8'd143, 8'd205, 8'd139, 8'd155,
                8'd212, 8'd172, 8'd189, 8'd57, 8'd199: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function bit mode_param(logic [7:0] p);
            case (p)
                8'd60, 8'd71, 8'd82, 8'd93, 8'd104, 8'd115, 8'd126: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // a counted bit that would answer from the response word before it was ever written
        function bit reads_blank(logic a, logic b);
            logic [15:0] nxt;
            if (!a || !prev_pause || rsp_written) return 1'b0;
            nxt = {window[14:0], b};
            case (nxt[15:8])
                CMD_PING, CMD_SON, CMD_SOF, CMD_SM: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void take_sample(logic a, logic b, logic [6:0] pins);
            logic [7:0] cmd;
            logic [7:0] par;
            bit         answers;
            t_rsp_bit   e;
            n_samples++;
            if (!a) begin
                prev_pause = 1'b1;
                return;
            end
            // repeated data symbol
            if (!prev_pause) return;
            prev_pause = 1'b0;
            window = {window[14:0], b};
            cmd = window[15:8];
            par = window[7:0];
            answers = 1'b1;
            case (cmd)
                CMD_PING: begin
                    rsp_word[15:8] = RSP_ACK;
                end
                CMD_SON, CMD_SOF: begin
                    if (switch_param(par)) begin
                        mode = MODE_CUSTOM;
                        rsp_word[15:8] = RSP_ACK;
                    end else begin
                        rsp_word[15:8] = RSP_NACK;
                    end
                end
                CMD_SM: begin
                    if (mode_param(par)) begin
                        mode = par;
                        rsp_word[15:8] = RSP_ACK;
                    end else begin
                        rsp_word[15:8] = RSP_NACK;
                    end
                end
                CMD_GM:    rsp_word = {RSP_ACK, mode};
                CMD_GSC:   rsp_word = {RSP_ACK, clk_byte};
                CMD_SSC: begin
                    rsp_word = {RSP_ACK, 8'h00};
                    clk_byte = par;
                end
                CMD_GOSTM: rsp_word = {RSP_ACK, pins, 1'b1};
                CMD_KEN:   rsp_word = {RSP_ACK, CMD_KEN};
                CMD_KDIS:  rsp_word = {RSP_ACK, CMD_KDIS};
                default:   answers = 1'b0;
            endcase
            if (answers) begin
                for (int k = 15; k >= 0; k--) begin
                    e.tx_bit   = rsp_word[k];
                    e.last_bit = (k == 0);
                    rsp_bits_q.push_back(e);
                end
                rsp_word    = '0;
                rsp_written = 1'b1;
                n_responses++;
            end
        endfunction

        function void check_tx_bit(logic tx, logic last);
            t_rsp_bit e;
            if (rsp_bits_q.size() == 0) begin
                $error("unexpected response bit: tx_bit %0b last_bit %0b", tx, last);
                errors++;
                return;
            end
            e = rsp_bits_q.pop_front();
            n_checked++;
            if (tx !== e.tx_bit) begin
                $error("tx_bit: expected %0b, actual %0b", e.tx_bit, tx);
                errors++;
            end
            if (last !== e.last_bit) begin
                $error("last_bit: expected %0b, actual %0b", e.last_bit, last);
                errors++;
            end
        endfunction

        function int pending();
            return rsp_bits_q.size();
        endfunction

    endclass

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL  = 40;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [7:0] CMD_LIST [10] = '{
        CMD_PING, CMD_SON, CMD_SOF, CMD_SM, CMD_GM,
        CMD_GSC, CMD_SSC, CMD_GOSTM, CMD_KEN, CMD_KDIS
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       i_line_a      = 1'b0;
    logic       i_line_b      = 1'b0;
    logic [6:0] i_status_pins = 7'h00;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_tx_bit;
    logic       o_last_bit;

    twcr_scoreboard sb = new();

    int         send_idle_pct   = 0;
    int         recv_idle_pct   = 0;
    int         sent_items      = 0;
    int         hold_reqs       = 0;
    int         holds_done      = 0;
    int         in_stall_cycles = 0;
    int         cycle_cnt       = 0;
    logic [7:0] last_byte       = 8'h00;

    two_wire_command_responder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_line_a      (i_line_a),
        .i_line_b      (i_line_b),
        .i_status_pins (i_status_pins),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tx_bit      (o_tx_bit),
        .o_last_bit    (o_last_bit)
    );

    always #5 i_clk = ~i_clk;

    // both channels sampled with pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.take_sample(i_line_a, i_line_b, i_status_pins);
            if (i_valid && o_stall) in_stall_cycles++;
            if (o_valid && !i_stall) sb.check_tx_bit(o_tx_bit, o_last_bit);
        end
    end

    // receiver: random stall, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d response bits outstanding",
                 cycle_cnt, sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_sample(input logic a, input logic b, input logic [6:0] pins);
        logic a_use;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        a_use = sb.reads_blank(a, b) ? 1'b0 : a;
        i_valid       <= 1'b1;
        i_line_a      <= a_use;
        i_line_b      <= b;
        i_status_pins <= pins;
        sent_items++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // pause symbol (with random line_b) followed by a data symbol
    task automatic send_bit(input logic b, input logic [6:0] pins);
        send_sample(1'b0, 1'($urandom_range(1)), 7'($urandom_range(127)));
        send_sample(1'b1, b, pins);
    endtask

    // shifts one byte msb first; pins go with its last bit, which completes
    // the command formed by the previous byte and this one
    task automatic send_byte(input logic [7:0] b, input logic [6:0] pins, input bit noisy);
        for (int i = 7; i >= 0; i--) begin
            if (noisy && $urandom_range(9) == 0)
                send_sample(1'b0, 1'($urandom_range(1)), 7'($urandom_range(127)));
            send_bit(b[i], (i == 0) ? pins : 7'($urandom_range(127)));
            if (noisy && $urandom_range(9) == 0)
                send_sample(1'b1, 1'($urandom_range(1)), 7'($urandom_range(127)));
        end
    endtask

    // a run of ones settles into back-to-back KEN answers
    task automatic send_burst(input int n);
        repeat (n) send_bit(1'b1, 7'($urandom_range(127)));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // next byte of the stream, biased toward a valid parameter after a command
    function automatic logic [7:0] pick_byte(input logic [7:0] prev);
        logic [7:0] b;
        b = CMD_LIST[$urandom_range(9)];
        if ($urandom_range(9) < 2) b = 8'($urandom_range(255));
        if ((prev == CMD_SON || prev == CMD_SOF) && $urandom_range(9) < 7)
            b = SWITCH_TARGETS[$urandom_range(N_SWITCH - 1)];
        if (prev == CMD_SM && $urandom_range(9) < 7)
            b = MODE_CODES[$urandom_range(N_MODES - 1)];
        return b;
    endfunction

    task automatic run_random_phase(input int n_items);
        int         start;
        int         kind;
        logic [7:0] b;
        start = sent_items;
        while (sent_items - start < n_items) begin
            kind = $urandom_range(9);
            if (kind <= 6) begin
                b = pick_byte(last_byte);
                send_byte(b, 7'($urandom_range(127)), 1'b1);
                last_byte = b;
            end else if (kind == 7) begin
                send_burst($urandom_range(2, 6));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                7'($urandom_range(127)));
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 29;
        recv_idle_pct = 70;

        // chained byte stream: each byte is the parameter of the command before it;
        // the first answer is a clock set, which writes the whole word
        send_byte(CMD_SSC, 7'h00, 1'b0);
        send_byte(CMD_GSC, 7'h00, 1'b0);
        send_byte(CMD_GOSTM, 7'h00, 1'b0);
        send_byte(CMD_KDIS, 7'h55, 1'b0);
        send_byte(CMD_PING, 7'h7F, 1'b0);
        send_byte(CMD_SM, 7'h00, 1'b0);
        send_byte(CMD_SON, 7'h00, 1'b0);
        send_byte(SWITCH_TARGETS[0], 7'h00, 1'b0);
        // pause with line_b high, then a data symbol repeated without a pause
        send_sample(1'b0, 1'b1, 7'h7F);
        send_sample(1'b1, 1'b1, 7'h00);
        send_sample(1'b1, 1'b0, 7'h7F);
        wait_drained();

        run_random_phase(16);
        wait_drained();

        send_idle_pct = 70;
        recv_idle_pct = 29;
        run_random_phase(16);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // output held off while a burst keeps coming, so the response queue fills
        hold_reqs++;
        send_burst(20);
        wait_drained();
        run_random_phase(16);

        wait_drained();
        repeat (DRAIN_TAIL) @(negedge i_clk);

        if (sb.pending() != 0)
            $error("%0d expected response bits never arrived", sb.pending());
        $display("covered %0d line samples, %0d responses, %0d response bits checked",
                 sb.n_samples, sb.n_responses, sb.n_checked);
        $display("input held back by stall in %0d cycles, %0d cycles in all",
                 in_stall_cycles, cycle_cnt);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
